@@ sv/llcs_pkg.sv @@
// shared types, character codes and lexing functions for the line lexer
// no dependencies; imported by every module of the block
`default_nettype none

package llcs_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_PAIR2,
      MODE_STRING
   } lex_mode_type;

   localparam logic [2:0] KIND_NONE      = 3'd0;
   localparam logic [2:0] KIND_INTEGER   = 3'd0;
   localparam logic [2:0] KIND_DECIMAL   = 3'd1;
   localparam logic [2:0] KIND_STRING    = 3'd2;
   localparam logic [2:0] KIND_BOOLEAN   = 3'd3;
   localparam logic [2:0] KIND_REFERENCE = 3'd4;
   localparam logic [2:0] KIND_SIMPLE    = 3'd5;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_APOS    = 8'h27;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_DIGIT_0 = 8'd48;
   localparam logic [7:0] CH_DIGIT_9 = 8'd57;
   localparam logic [7:0] CH_UPPER_A = 8'd65;
   localparam logic [7:0] CH_UPPER_Z = 8'd90;
   localparam logic [7:0] CASE_SHIFT = 8'd32;

   // result buffer geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   typedef struct packed {
      lex_mode_type mode;
      logic         chars;
      logic         all_digits;
      logic [1:0]   points;
      logic [4:0]   bool_match;
      logic         first_upper;
   } lex_state_type;

   localparam lex_state_type LEX_STATE_RESET = '{
      mode:        MODE_IDLE,
      chars:       1'b0,
      all_digits:  1'b1,
      points:      2'd0,
      bool_match:  5'd0,
      first_upper: 1'b0
   };

   typedef struct packed {
      logic [7:0] c0;
      logic       e0;
      logic       has1;
      logic       known1;
      logic [7:0] c1;
      logic       has2;
      logic       known2;
      logic [7:0] c2;
   } look_type;

   typedef struct packed {
      logic [7:0] tok_char;
      logic       char_valid;
      logic [7:0] token_index;
      logic       token_first;
      logic       token_last;
      logic [2:0] token_kind;
      logic       run_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type slot0;
      result_type slot1;
   } lex_out_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
   endfunction

   // ! @ # $ % ^ * ( ) - + = [ ] { } \ : ; < > , . / ? ~ ` & |
   function automatic logic is_punct(input logic [7:0] c);
      return c inside {8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h2A, 8'h28, 8'h29,
                       8'h2D, 8'h2B, 8'h3D, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h5C, 8'h3A,
                       8'h3B, 8'h3C, 8'h3E, 8'h2C, 8'h2E, 8'h2F, 8'h3F, 8'h7E, 8'h60,
                       8'h26, 8'h7C};
   endfunction

   // & | = ! > < '
   function automatic logic starts_pair(input logic [7:0] c);
      return c inside {8'h26, 8'h7C, 8'h3D, 8'h21, 8'h3E, 8'h3C, CH_APOS};
   endfunction

   // && || == != >= <= 's
   function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
      return ((a == 8'h26) && (b == 8'h26)) || ((a == 8'h7C) && (b == 8'h7C)) ||
             ((a == 8'h3D) && (b == 8'h3D)) || ((a == 8'h21) && (b == 8'h3D)) ||
             ((a == 8'h3E) && (b == 8'h3D)) || ((a == 8'h3C) && (b == 8'h3D)) ||
             ((a == CH_APOS) && (b == 8'h73));
   endfunction

   function automatic logic word_joins(input logic [7:0] c, input logic [7:0] prev_c,
                                       input logic has_after, input logic [7:0] after);
      logic joins;
      if (c == CH_SPACE) begin
         joins = 1'b0;
      end else if (c == CH_DOT) begin
         joins = is_digit(prev_c) && has_after && is_digit(after);
      end else if (has_after && is_pair(c, after)) begin
         joins = 1'b0;
      end else begin
         joins = !is_punct(c);
      end
      return joins;
   endfunction

   // lower-case spelling of true
   function automatic logic [7:0] true_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h74;
         3'd1:    c = 8'h72;
         3'd2:    c = 8'h75;
         3'd3:    c = 8'h65;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // lower-case spelling of false
   function automatic logic [7:0] false_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h66;
         3'd1:    c = 8'h61;
         3'd2:    c = 8'h6C;
         3'd3:    c = 8'h73;
         3'd4:    c = 8'h65;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] word_kind(input lex_state_type st);
      logic [2:0] len;
      logic [2:0] kind;
      len = st.bool_match[4:2];
      if (st.all_digits && (st.points == 2'd0)) begin
         kind = KIND_INTEGER;
      end else if (st.all_digits && (st.points == 2'd1)) begin
         kind = KIND_DECIMAL;
      end else if ((st.bool_match[0] && (len == 3'd4)) ||
                   (st.bool_match[1] && (len == 3'd5))) begin
         kind = KIND_BOOLEAN;
      end else if (st.first_upper) begin
         kind = KIND_REFERENCE;
      end else begin
         kind = KIND_SIMPLE;
      end
      return kind;
   endfunction

endpackage

`default_nettype wire

@@ sv/line_lexer_char_stream_unit.sv @@
// line lexer over a character stream: top level with input register and result buffer
// uses llcs_pkg, llcs_lexer and llcs_rsp_fifo
//
// req channel: one line character per beat, req_tlast on the line's last character.
// rsp channel: one token character per beat with its token number, first/last marks
// and, on the last character, the token class; rsp_tlast marks the final result
// caused by a request beat, and an empty string arrives as a beat with char_valid 0.
// a beat is registered, then lexed against up to two held lookahead characters by
// three chained character steps, which write zero, one or two results into a
// four-entry buffer. a result leaves only after the beat that completes it has passed
// the input register and the buffer; a character waits for at most two later characters
// that decide where its token ends. one request beat is taken every cycle while the
// buffer has two free entries; results drain at one beat per cycle.
// when the receiver stalls the buffer fills and req_tready drops until it drains.
// reset empties the input register, the held characters and the buffer, and
// restarts token numbering; the block is ready as soon as reset is released.
`default_nettype none

module line_lexer_char_stream_unit import llcs_pkg::*; #(
   parameter int MAX_TOKENS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // tok_char, token_index
   output logic [5:0]  rsp_tuser,   // char_valid, token_first, token_last, token_kind
   output logic        rsp_tlast
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_ch_ff;
   logic        in_end_ff;
   logic        fifo_room;
   logic        proc;
   logic        accept;
   lex_out_type lex_out;
   result_type  rsp_res;

   assign proc       = in_valid_ff && fifo_room;
   assign req_tready = !in_valid_ff || fifo_room;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ch_ff  <= req_tdata;
         in_end_ff <= req_tlast;
      end
   end

   llcs_lexer #(
      .MAX_TOKENS(MAX_TOKENS)
   ) u_lexer (
      .clock   (clock),
      .reset   (reset),
      .proc    (proc),
      .in_ch   (in_ch_ff),
      .in_end  (in_end_ff),
      .lex_out (lex_out)
   );

   llcs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .lex_out   (lex_out),
      .rd        (rsp_tvalid && rsp_tready),
      .room      (fifo_room),
      .out_valid (rsp_tvalid),
      .out_res   (rsp_res)
   );

   assign rsp_tdata = {rsp_res.token_index, rsp_res.tok_char};
   assign rsp_tuser = {rsp_res.token_kind, rsp_res.token_last, rsp_res.token_first,
                       rsp_res.char_valid};
   assign rsp_tlast = rsp_res.run_last;

`ifndef ASSERT_OFF
   // a registered beat waits for buffer room without being lost
   a_hold_in_beat: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fifo_room |=> in_valid_ff && $stable(in_ch_ff) && $stable(in_end_ff))
      else $error("input beat dropped while result buffer full");

   // an empty string result is a whole string token
   a_empty_string: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_res.char_valid |->
         rsp_res.token_first && rsp_res.token_last && (rsp_res.token_kind == KIND_STRING))
      else $error("result without character is not an empty string token");

   // the class only travels on a token's last character
   a_kind_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_res.token_last |-> rsp_res.token_kind == KIND_NONE)
      else $error("token class on a character that is not last");

   // nothing to send right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result beat valid right after reset");
`endif

endmodule

`default_nettype wire

@@ sv/llcs_step.sv @@
// one character position of the lexer: decides skip, wait or emit for the head byte
// uses llcs_pkg; instantiated once for each of the three chained steps by llcs_lexer
`default_nettype none

module llcs_step import llcs_pkg::*; #(
   parameter int MAX_TOKENS = 256
) (
   input  logic                          active,
   input  lex_state_type                 st_in,
   input  logic [$clog2(MAX_TOKENS)-1:0] count_in,
   input  look_type                      look,
   output lex_state_type                 st_out,
   output logic [$clog2(MAX_TOKENS)-1:0] count_out,
   output logic                          pop,
   output logic                          emit,
   output result_type                    res
);

   localparam int CW = $clog2(MAX_TOKENS);
   localparam int XW = (CW > 8) ? CW : 8;
   localparam logic [CW-1:0] COUNT_TOP = CW'(MAX_TOKENS - 1);

   lex_state_type word_base;
   lex_state_type word_abs;
   lex_state_type word_fin;
   logic [7:0]    low_char;
   logic [2:0]    blen;
   logic [2:0]    alen;
   logic          bt;
   logic          bf;
   logic          word_ready;
   logic          word_last;
   logic          take_word;
   logic          do_reset;
   logic [7:0]    e_char;
   logic          e_valid;
   logic          e_first;
   logic          e_last;
   logic [2:0]    e_kind;
   logic [CW-1:0] count_inc;
   logic [XW-1:0] count_ext;

   // word path: running class flags with this byte taken in
   always_comb begin
      if (st_in.mode == MODE_IDLE) begin
         word_base = LEX_STATE_RESET;
      end else begin
         word_base = st_in;
      end
      word_base.mode = MODE_WORD;
      word_abs = word_base;
      low_char = is_upper(look.c0) ? (look.c0 + CASE_SHIFT) : look.c0;
      if (!word_base.chars) begin
         word_abs.first_upper = is_upper(look.c0);
         word_abs.bool_match  = 5'b00011;
      end
      if (!is_digit(look.c0) && (look.c0 != CH_DOT)) begin
         word_abs.all_digits = 1'b0;
      end
      if ((look.c0 == CH_DOT) && (word_base.points != 2'd2)) begin
         word_abs.points = word_base.points + 2'd1;
      end
      blen = word_abs.bool_match[4:2];
      bt   = word_abs.bool_match[0] && (blen < 3'd4) && (true_char(blen) == low_char);
      bf   = word_abs.bool_match[1] && (blen < 3'd5) && (false_char(blen) == low_char);
      alen = (blen == 3'd7) ? blen : (blen + 3'd1);
      word_abs.bool_match = {alen, bf, bt};
      word_ready = look.known1 &&
                   !(look.has1 && ((look.c1 == CH_DOT) || (look.c1 == CH_APOS)) &&
                     !look.known2);
      word_last  = !(look.has1 && word_joins(look.c1, look.c0, look.has2, look.c2));
      word_fin = word_abs;
      word_fin.chars = 1'b1;
      if (word_last) begin
         word_fin.mode  = MODE_IDLE;
         word_fin.chars = 1'b0;
      end
   end

   always_comb begin
      st_out    = st_in;
      pop       = 1'b0;
      emit      = 1'b0;
      e_char    = look.c0;
      e_valid   = 1'b1;
      e_first   = 1'b0;
      e_last    = 1'b0;
      e_kind    = KIND_SIMPLE;
      do_reset  = 1'b0;
      take_word = 1'b0;
      if (active) begin
         case (st_in.mode)
            MODE_IDLE: begin
               if (look.c0 == CH_SPACE) begin
                  pop      = 1'b1;
                  do_reset = look.e0;
               end else if (look.c0 == CH_QUOTE) begin
                  pop = 1'b1;
                  if (look.e0) begin
                     // quote closing the line: empty string
                     emit     = 1'b1;
                     e_valid  = 1'b0;
                     e_char   = 8'h00;
                     e_first  = 1'b1;
                     e_last   = 1'b1;
                     e_kind   = KIND_STRING;
                     do_reset = 1'b1;
                  end else begin
                     st_out.mode  = MODE_STRING;
                     st_out.chars = 1'b0;
                  end
               end else if (starts_pair(look.c0) && !look.known1) begin
                  st_out = st_in;
               end else if (starts_pair(look.c0) && look.has1 && is_pair(look.c0, look.c1)) begin
                  emit        = 1'b1;
                  e_first     = 1'b1;
                  pop         = 1'b1;
                  st_out.mode = MODE_PAIR2;
               end else if (is_punct(look.c0)) begin
                  emit     = 1'b1;
                  e_first  = 1'b1;
                  e_last   = 1'b1;
                  pop      = 1'b1;
                  do_reset = look.e0;
               end else begin
                  take_word = 1'b1;
               end
            end
            MODE_PAIR2: begin
               emit        = 1'b1;
               e_last      = 1'b1;
               pop         = 1'b1;
               st_out.mode = MODE_IDLE;
               do_reset    = look.e0;
            end
            MODE_STRING: begin
               if (look.c0 == CH_QUOTE) begin
                  pop = 1'b1;
                  if (!st_in.chars) begin
                     emit    = 1'b1;
                     e_valid = 1'b0;
                     e_char  = 8'h00;
                     e_first = 1'b1;
                     e_last  = 1'b1;
                     e_kind  = KIND_STRING;
                  end
                  st_out.mode  = MODE_IDLE;
                  st_out.chars = 1'b0;
                  do_reset     = look.e0;
               end else if (look.known1) begin
                  emit         = 1'b1;
                  e_first      = !st_in.chars;
                  e_last       = !look.has1 || (look.c1 == CH_QUOTE);
                  e_kind       = KIND_STRING;
                  pop          = 1'b1;
                  st_out.chars = 1'b1;
                  do_reset     = look.e0;
               end
            end
            MODE_WORD: begin
               take_word = 1'b1;
            end
            default: begin
               st_out = st_in;
            end
         endcase
         if (take_word) begin
            if (word_ready) begin
               emit     = 1'b1;
               e_first  = !word_base.chars;
               e_last   = word_last;
               e_kind   = word_kind(word_abs);
               pop      = 1'b1;
               st_out   = word_fin;
               do_reset = look.e0;
            end else begin
               st_out = word_base;
            end
         end
      end
      if (do_reset) begin
         st_out = LEX_STATE_RESET;
      end
   end

   // token number wraps modulo MAX_TOKENS and restarts at each line end
   always_comb begin
      count_inc = (count_in == COUNT_TOP) ? '0 : (count_in + 1'b1);
      if (do_reset) begin
         count_out = '0;
      end else if (emit && e_last) begin
         count_out = count_inc;
      end else begin
         count_out = count_in;
      end
      count_ext       = XW'(count_in);
      res.tok_char    = e_char;
      res.char_valid  = e_valid;
      res.token_index = count_ext[7:0];
      res.token_first = e_first;
      res.token_last  = e_last;
      res.token_kind  = e_last ? e_kind : KIND_NONE;
      res.run_last    = 1'b0;
   end

endmodule

`default_nettype wire

@@ sv/llcs_lexer.sv @@
// lexer core: held lookahead bytes, token state and three chained character steps
// uses llcs_pkg and llcs_step; emits up to two results per input beat
`default_nettype none

module llcs_lexer import llcs_pkg::*; #(
   parameter int MAX_TOKENS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        proc,
   input  logic [7:0]  in_ch,
   input  logic        in_end,
   output lex_out_type lex_out
);

   localparam int CW = $clog2(MAX_TOKENS);

   logic [7:0]    q_char_ff [2];
   logic [7:0]    q_char_in [2];
   logic          q_end_ff [2];
   logic          q_end_in [2];
   logic [1:0]    q_cnt_ff;
   logic [1:0]    q_cnt_in;
   lex_state_type st_ff;
   lex_state_type st_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic [7:0]    win_char [5];
   logic          win_end [5];
   logic [2:0]    win_cnt;
   look_type      look [3];
   lex_state_type st_chain [4];
   logic [CW-1:0] cnt_chain [4];
   logic          act [3];
   logic          pop [3];
   logic          emit [3];
   result_type    res [3];
   logic [2:0]    pops;
   logic [2:0]    rem;

   // window: held bytes followed by the new one
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         win_char[i] = 8'h00;
         win_end[i]  = 1'b0;
      end
      case (q_cnt_ff)
         2'd1: begin
            win_char[0] = q_char_ff[0];
            win_end[0]  = q_end_ff[0];
            win_char[1] = in_ch;
            win_end[1]  = in_end;
         end
         2'd2: begin
            win_char[0] = q_char_ff[0];
            win_end[0]  = q_end_ff[0];
            win_char[1] = q_char_ff[1];
            win_end[1]  = q_end_ff[1];
            win_char[2] = in_ch;
            win_end[2]  = in_end;
         end
         default: begin
            win_char[0] = in_ch;
            win_end[0]  = in_end;
         end
      endcase
      win_cnt = 3'(q_cnt_ff) + 3'd1;
   end

   assign st_chain[0]  = st_ff;
   assign cnt_chain[0] = count_ff;
   assign act[0] = proc;
   assign act[1] = act[0] && pop[0] && (3'd1 < win_cnt);
   assign act[2] = act[1] && pop[1] && !(emit[0] && emit[1]) && (3'd2 < win_cnt);

   for (genvar j = 0; j < 3; j++) begin : g_pos
      logic e1;
      always_comb begin
         look[j].c0     = win_char[j];
         look[j].e0     = win_end[j];
         look[j].has1   = !win_end[j] && (3'(j + 1) < win_cnt);
         look[j].known1 = win_end[j] || (3'(j + 1) < win_cnt);
         look[j].c1     = look[j].has1 ? win_char[j + 1] : 8'h00;
         e1             = look[j].has1 ? win_end[j + 1] : 1'b1;
         look[j].has2   = look[j].has1 && !e1 && (3'(j + 2) < win_cnt);
         look[j].known2 = !look[j].has1 || e1 || (3'(j + 2) < win_cnt);
         look[j].c2     = look[j].has2 ? win_char[j + 2] : 8'h00;
      end

      llcs_step #(
         .MAX_TOKENS(MAX_TOKENS)
      ) u_step (
         .active    (act[j]),
         .st_in     (st_chain[j]),
         .count_in  (cnt_chain[j]),
         .look      (look[j]),
         .st_out    (st_chain[j + 1]),
         .count_out (cnt_chain[j + 1]),
         .pop       (pop[j]),
         .emit      (emit[j]),
         .res       (res[j])
      );
   end

   always_comb begin
      pops = 3'(pop[0]) + 3'(pop[1]) + 3'(pop[2]);
      rem  = win_cnt - pops;
      q_char_in[0] = win_char[pops];
      q_end_in[0]  = win_end[pops];
      q_char_in[1] = win_char[pops + 3'd1];
      q_end_in[1]  = win_end[pops + 3'd1];
      q_cnt_in     = rem[1:0];
      st_in        = st_chain[3];
      count_in     = cnt_chain[3];
   end

   // gather emitted results in order, mark the final one of the beat
   always_comb begin
      lex_out.count = 2'(emit[0]) + 2'(emit[1]) + 2'(emit[2]);
      if (emit[0]) begin
         lex_out.slot0 = res[0];
      end else if (emit[1]) begin
         lex_out.slot0 = res[1];
      end else begin
         lex_out.slot0 = res[2];
      end
      if (emit[0] && emit[1]) begin
         lex_out.slot1 = res[1];
      end else begin
         lex_out.slot1 = res[2];
      end
      lex_out.slot0.run_last = (lex_out.count == 2'd1);
      lex_out.slot1.run_last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff    <= 2'd0;
         st_ff       <= LEX_STATE_RESET;
         count_ff    <= '0;
         q_char_ff[0] <= 8'h00;
         q_char_ff[1] <= 8'h00;
         q_end_ff[0]  <= 1'b0;
         q_end_ff[1]  <= 1'b0;
      end else if (proc) begin
         q_cnt_ff     <= q_cnt_in;
         st_ff        <= st_in;
         count_ff     <= count_in;
         q_char_ff[0] <= q_char_in[0];
         q_char_ff[1] <= q_char_in[1];
         q_end_ff[0]  <= q_end_in[0];
         q_end_ff[1]  <= q_end_in[1];
      end
   end

endmodule

`default_nettype wire

@@ sv/llcs_rsp_fifo.sv @@
// result buffer: takes up to two results per cycle, hands out one per cycle on rd
// uses llcs_pkg for the result type and buffer depth
`default_nettype none

module llcs_rsp_fifo import llcs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  lex_out_type lex_out,
   input  logic        rd,
   output logic        room,
   output logic        out_valid,
   output result_type  out_res
);

   result_type           mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_in;
   logic [RSP_PTR_W:0]   fill_ff;
   logic [RSP_PTR_W:0]   fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(lex_out.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(rd);
      fill_in   = fill_ff + (RSP_PTR_W + 1)'(lex_out.count) - (RSP_PTR_W + 1)'(rd);
   end

   assign room      = (fill_ff <= (RSP_PTR_W + 1)'(RSP_DEPTH - 2));
   assign out_valid = (fill_ff != '0);
   assign out_res   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (lex_out.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= lex_out.slot0;
      end
      if (lex_out.count == 2'd2) begin
         mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= lex_out.slot1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

@@ sim/line_lexer_char_stream_unit_test.sv @@
// testbench for line_lexer_char_stream_unit: sends text lines as character beats,
// predicts every token beat and checks it field by field
// needs llcs_pkg and the block's rtl
`timescale 1ns / 100ps

module line_lexer_char_stream_unit_test;
   import llcs_pkg::*;

   localparam int TOKEN_LIMIT     = 256;
   localparam int HOLD_DEPTH      = 8;
   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_CYCLES = 200;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // ch
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // tok_char, token_index
   logic [5:0]  rsp_tuser;            // char_valid, token_first, token_last, token_kind
   logic        rsp_tlast;

   // lexer state kept by the predictor
   logic [8:0]   held_chars[$];
   lex_mode_type scan_mode      = MODE_IDLE;
   bit           string_pending = 1'b0;
   bit           word_started   = 1'b0;
   bit           word_digits    = 1'b1;
   bit           spells_true    = 1'b0;
   bit           spells_false   = 1'b0;
   bit           starts_upper   = 1'b0;
   logic [1:0]   dot_count      = 2'd0;
   logic [2:0]   spell_len      = 3'd0;
   int           token_number   = 0;
   result_type   step_results[$];
   result_type   expected_results[$];

   string punct_chars = "!@#$%^*()-+=[]{}\\:;<>,./?~&|";
   string pair_chars  = "&&||==!=>=<='s";
   string true_text   = "true";
   string false_text  = "false";

   logic [7:0] line_buf[$];
   int         burst_left   = 0;
   int         mismatches   = 0;
   int         results_seen = 0;
   int         quiet_cycles = 0;
   bit         hold_request = 1'b0;
   bit         hold_done    = 1'b0;
   int         hold_left    = 0;
   int         pattern_left = 0;
   int         stall_pct    = 0;

   line_lexer_char_stream_unit #(.MAX_TOKENS(TOKEN_LIMIT)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic bit is_numeral(logic [7:0] c);
      return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
   endfunction

   function automatic bit char_is_punct(logic [7:0] c);
      if (c == 8'h60) return 1'b1;   // backtick
      for (int i = 0; i < punct_chars.len(); i++) begin
         if (punct_chars[i] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit opens_pair(logic [7:0] c);
      for (int i = 0; i < pair_chars.len(); i += 2) begin
         if (pair_chars[i] == c) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit forms_pair(logic [7:0] a, logic [7:0] b);
      for (int i = 0; i < pair_chars.len(); i += 2) begin
         if ((pair_chars[i] == a) && (pair_chars[i + 1] == b)) return 1'b1;
      end
      return 1'b0;
   endfunction

   // does c stay in the word that ends with prior
   function automatic bit continues_word(logic [7:0] c, logic [7:0] prior, bit has_next,
                                         logic [7:0] next_c);
      if (c == CH_SPACE) return 1'b0;
      if (c == CH_DOT) return is_numeral(prior) && has_next && is_numeral(next_c);
      if (has_next && forms_pair(c, next_c)) return 1'b0;
      return !char_is_punct(c);
   endfunction

   function automatic void clear_word();
      word_digits  = 1'b1;
      dot_count    = 2'd0;
      spells_true  = 1'b0;
      spells_false = 1'b0;
      spell_len    = 3'd0;
      starts_upper = 1'b0;
   endfunction

   function automatic void restart_line();
      token_number   = 0;
      scan_mode      = MODE_IDLE;
      word_started   = 1'b0;
      string_pending = 1'b0;
      clear_word();
   endfunction

   function automatic void take_word_char(logic [7:0] c);
      logic       upper;
      logic [7:0] low;
      upper = (c >= CH_UPPER_A) && (c <= CH_UPPER_Z);
      low = upper ? c + CASE_SHIFT : c;
      if (!word_started) begin
         starts_upper = upper;
         spells_true  = 1'b1;
         spells_false = 1'b1;
         spell_len    = 3'd0;
      end
      if (!is_numeral(c) && (c != CH_DOT)) word_digits = 1'b0;
      if ((c == CH_DOT) && (dot_count < 2'd2)) dot_count = dot_count + 2'd1;
      if (!((spell_len < 3'd4) && (low == true_text[spell_len]))) spells_true = 1'b0;
      if (!((spell_len < 3'd5) && (low == false_text[spell_len]))) spells_false = 1'b0;
      if (spell_len < 3'd7) spell_len = spell_len + 3'd1;
   endfunction

   function automatic logic [2:0] classify_word();
      if (word_digits && (dot_count == 2'd0)) return KIND_INTEGER;
      if (word_digits && (dot_count == 2'd1)) return KIND_DECIMAL;
      if ((spells_true && (spell_len == 3'd4)) || (spells_false && (spell_len == 3'd5)))
         return KIND_BOOLEAN;
      if (starts_upper) return KIND_REFERENCE;
      return KIND_SIMPLE;
   endfunction

   function automatic void push_result(logic [7:0] c, bit valid, bit first, bit last,
                                       logic [2:0] kind);
      result_type r;
      r.tok_char    = valid ? c : 8'h00;
      r.char_valid  = valid;
      r.token_index = token_number[7:0];
      r.token_first = first;
      r.token_last  = last;
      r.token_kind  = last ? kind : KIND_NONE;
      r.run_last    = 1'b0;
      step_results.insert(step_results.size(), r);
      if (last) token_number = (token_number + 1) % TOKEN_LIMIT;
   endfunction

   // lex one accepted character and queue the token beats it releases
   function automatic void predict_char(logic [7:0] ch, logic eol);
      logic [7:0] c0, c1, c2;
      logic       e0, e1, has1, has2, known1, known2, joins, last;
      result_type r;
      if (held_chars.size() < HOLD_DEPTH) held_chars.insert(held_chars.size(), {eol, ch});
      step_results.delete();
      while (step_results.size() < 2) begin
         if (string_pending) begin
            push_result(8'h00, 1'b0, 1'b1, 1'b1, KIND_STRING);
            restart_line();
            continue;
         end
         if (held_chars.size() == 0) break;
         c0 = held_chars[0][7:0];
         e0 = held_chars[0][8];
         has1 = !e0 && (held_chars.size() > 1);
         known1 = e0 || (held_chars.size() > 1);
         c1 = has1 ? held_chars[1][7:0] : 8'h00;
         e1 = has1 ? held_chars[1][8] : 1'b1;
         has2 = has1 && !e1 && (held_chars.size() > 2);
         known2 = !has1 || e1 || (held_chars.size() > 2);
         c2 = has2 ? held_chars[2][7:0] : 8'h00;
         case (scan_mode)
            MODE_IDLE: begin
               if (c0 == CH_SPACE) begin
                  void'(held_chars.pop_front());
                  if (e0) restart_line();
               end else if (c0 == CH_QUOTE) begin
                  void'(held_chars.pop_front());
                  scan_mode = MODE_STRING;
                  word_started = 1'b0;
                  if (e0) string_pending = 1'b1;
               end else if (opens_pair(c0) && !known1) begin
                  break;
               end else if (has1 && forms_pair(c0, c1)) begin
                  push_result(c0, 1'b1, 1'b1, 1'b0, KIND_NONE);
                  void'(held_chars.pop_front());
                  scan_mode = MODE_PAIR2;
               end else if (char_is_punct(c0)) begin
                  push_result(c0, 1'b1, 1'b1, 1'b1, KIND_SIMPLE);
                  void'(held_chars.pop_front());
                  if (e0) restart_line();
               end else begin
                  scan_mode = MODE_WORD;
                  word_started = 1'b0;
                  clear_word();
               end
            end
            MODE_PAIR2: begin
               push_result(c0, 1'b1, 1'b0, 1'b1, KIND_SIMPLE);
               void'(held_chars.pop_front());
               scan_mode = MODE_IDLE;
               if (e0) restart_line();
            end
            MODE_STRING: begin
               if (c0 == CH_QUOTE) begin
                  void'(held_chars.pop_front());
                  if (!word_started) push_result(8'h00, 1'b0, 1'b1, 1'b1, KIND_STRING);
                  scan_mode = MODE_IDLE;
                  word_started = 1'b0;
                  if (e0) restart_line();
               end else if (!known1) begin
                  break;
               end else begin
                  last = !has1 || (c1 == CH_QUOTE);
                  push_result(c0, 1'b1, !word_started, last, KIND_STRING);
                  word_started = 1'b1;
                  void'(held_chars.pop_front());
                  if (e0) restart_line();
               end
            end
            default: begin
               if (!known1) break;
               joins = 1'b0;
               if (has1) begin
                  if (((c1 == CH_DOT) || (c1 == CH_APOS)) && !known2) break;
                  joins = continues_word(c1, c0, has2, c2);
               end
               take_word_char(c0);
               last = !joins;
               push_result(c0, 1'b1, !word_started, last,
                           last ? classify_word() : KIND_NONE);
               word_started = 1'b1;
               void'(held_chars.pop_front());
               if (last) begin
                  scan_mode = MODE_IDLE;
                  word_started = 1'b0;
               end
               if (e0) restart_line();
            end
         endcase
      end
      if (step_results.size() > 0) begin
         r = step_results[step_results.size() - 1];
         r.run_last = 1'b1;
         step_results[step_results.size() - 1] = r;
      end
      foreach (step_results[i]) expected_results.insert(expected_results.size(), step_results[i]);
   endfunction

   task automatic report_mismatch(string what, int got_v, int want_v);
      $display("mismatch at beat %0d: %s got %0h, expected %0h", results_seen, what,
               got_v, want_v);
      mismatches++;
   endtask

   task automatic compare_field(string what, int got_v, int want_v);
      if (got_v != want_v) report_mismatch(what, got_v, want_v);
   endtask

   task automatic check_result();
      result_type seen, want;
      seen.tok_char    = rsp_tdata[7:0];
      seen.token_index = rsp_tdata[15:8];
      seen.char_valid  = rsp_tuser[0];
      seen.token_first = rsp_tuser[1];
      seen.token_last  = rsp_tuser[2];
      seen.token_kind  = rsp_tuser[5:3];
      seen.run_last    = rsp_tlast;
      if (expected_results.size() == 0) begin
         report_mismatch("beat with nothing expected, index/char",
                         {seen.token_index, seen.tok_char}, 0);
      end else begin
         want = expected_results.pop_front();
         compare_field("tok_char", seen.tok_char, want.tok_char);
         compare_field("char_valid", seen.char_valid, want.char_valid);
         compare_field("token_index", seen.token_index, want.token_index);
         compare_field("token_first", seen.token_first, want.token_first);
         compare_field("token_last", seen.token_last, want.token_last);
         compare_field("token_kind", seen.token_kind, want.token_kind);
         compare_field("run_last", seen.run_last, want.run_last);
      end
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) predict_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: one long hold-off on request, otherwise stall stretches of random density
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(4, 60);
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 30;
               2:       stall_pct = 60;
               default: stall_pct = 90;
            endcase
         end
         pattern_left = pattern_left - 1;
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_char(logic [7:0] ch, bit eol);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eol;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_line_buf();
      for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   function automatic void append_byte(logic [7:0] c);
      line_buf.insert(line_buf.size(), c);
   endfunction

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   function automatic logic [7:0] random_digit();
      return CH_DIGIT_0 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_lower();
      return CH_UPPER_A + CASE_SHIFT + 8'($urandom_range(0, 25));
   endfunction

   task automatic add_random_token();
      int         k;
      string      w;
      logic [7:0] c;
      case ($urandom_range(0, 11))
         0: repeat ($urandom_range(1, 4)) append_byte(random_digit());
         1: begin
            repeat ($urandom_range(1, 3)) append_byte(random_digit());
            append_byte(CH_DOT);
            repeat ($urandom_range(0, 2)) append_byte(random_digit());
            if ($urandom_range(0, 4) == 0) add_text(".7");
         end
         2: begin
            w = $urandom_range(0, 1) ? true_text : false_text;
            for (int i = 0; i < w.len(); i++) begin
               c = w[i];
               if ($urandom_range(0, 1)) c = c - CASE_SHIFT;
               append_byte(c);
            end
            if ($urandom_range(0, 3) == 0) append_byte(random_lower());
         end
         3: begin
            append_byte(CH_UPPER_A + 8'($urandom_range(0, 25)));
            repeat ($urandom_range(0, 4)) append_byte(random_lower());
         end
         4: begin
            repeat ($urandom_range(1, 5)) append_byte(random_lower());
            case ($urandom_range(0, 3))
               0: add_text("'s");
               1: begin
                  append_byte(CH_APOS);
                  append_byte(random_lower());
               end
               2: append_byte(random_digit());
               default: ;
            endcase
         end
         5: begin
            append_byte(CH_QUOTE);
            repeat ($urandom_range(0, 4)) begin
               c = 8'($urandom_range(32, 126));
               if (c == CH_QUOTE) c = CH_SPACE;
               append_byte(c);
            end
            if ($urandom_range(0, 4) != 0) append_byte(CH_QUOTE);
         end
         6: begin
            append_byte(CH_QUOTE);
            append_byte(CH_QUOTE);
         end
         7: begin
            k = $urandom_range(0, 6);
            append_byte(pair_chars[2 * k]);
            append_byte(pair_chars[2 * k + 1]);
         end
         8: begin
            if ($urandom_range(0, 9) == 0) append_byte(8'h60);
            else append_byte(punct_chars[$urandom_range(0, punct_chars.len() - 1)]);
         end
         9: repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(128, 255)));
         10: append_byte(8'($urandom_range(33, 126)));
         default: begin
            append_byte($urandom_range(0, 1) ? random_digit() : random_lower());
            append_byte(CH_DOT);
            append_byte($urandom_range(0, 1) ? random_digit() : random_lower());
         end
      endcase
   endtask

   task automatic build_random_line();
      if ($urandom_range(0, 7) == 0) append_byte(CH_SPACE);
      repeat ($urandom_range(1, 10)) begin
         add_random_token();
         case ($urandom_range(0, 3))
            0:       ;
            3:       add_text("  ");
            default: append_byte(CH_SPACE);
         endcase
      end
   endtask

   task automatic test_token_classes();
      add_text("1.5 TRUE!=Ab");
      send_line_buf();
   endtask

   // quote inside a word, two quotes in a row, quote as the line's last byte, unclosed string
   task automatic test_strings();
      add_text("x\"y \"\" \"");
      send_line_buf();
      add_text("\"ab");
      send_line_buf();
   endtask

   task automatic test_byte_extremes();
      append_byte(8'h00);
      append_byte(8'hFF);
      add_text("'s");
      send_line_buf();
   endtask

   task automatic test_random_lines(int char_goal);
      int sent;
      sent = 0;
      while (sent < char_goal) begin
         build_random_line();
         sent += line_buf.size();
         send_line_buf();
      end
   endtask

   task automatic test_receiver_hold_off();
      hold_request = 1'b1;
      test_random_lines(120);
   endtask

   task automatic test_token_index_wrap();
      string wrap_chars;
      wrap_chars = "(){}[]#$%*+-,;/?~@^:";
      repeat (300) append_byte(wrap_chars[$urandom_range(0, wrap_chars.len() - 1)]);
      send_line_buf();
   endtask

   task automatic test_noise_bytes(int count);
      for (int i = 0; i < count; i++) begin
         send_char(8'($urandom_range(0, 255)), (i == count - 1) || ($urandom_range(0, 11) == 0));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_token_classes();
      test_strings();
      test_byte_extremes();
      test_random_lines(700);
      test_receiver_hold_off();
      test_token_index_wrap();
      test_noise_bytes(150);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
